>>> hdl/fntp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fntp_pkg: shared types and constants of the number token parser
// Character classes, the item that travels from the front to the back,
// character codes and the digit decoder.
// ----------------------------------------------------------------------------
package fntp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned POS_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CHAR_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE  = 8'h27;

  localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RESET_BASE  = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;

  localparam logic [MAG_W-1:0] MAG_MAX = 31'h7FFF_FFFF;

  localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
  localparam logic [POS_W-1:0] POS_THIRD  = 2'd2;
  localparam logic [POS_W-1:0] POS_LATER  = 2'd3;

  typedef enum logic [2:0] {
    CH_PFX_DEC,
    CH_PFX_HEX,
    CH_PFX_BIN,
    CH_MINUS,
    CH_PLAIN
  } ch_class_e;

  typedef struct packed {
    ch_class_e           ch_class;
    logic [RADIX_W-1:0]  digit;
    logic [POS_W-1:0]    pos;
    logic                last;
    logic                is_quote;
    logic [CHAR_W-1:0]   char_code;
  } tok_item_t;

  // Value of an alphanumeric character, DIGIT_NONE for anything else.
  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    begin
      d = CHAR_W'(DIGIT_NONE);
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41 + 8'd10;
      end
      digit_of = d[RADIX_W-1:0];
    end
  endfunction

endpackage

>>> hdl/fntp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fntp_front: character intake and classification
// Tracks the position of each character in its token and tags it with its
// class and digit value before it enters the queue.
// ----------------------------------------------------------------------------
module fntp_front import fntp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              last_char_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output tok_item_t         q_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign q_push_o   = accept;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_char_i) begin
        pos_d = POS_FIRST;
      end else if (pos_q != POS_LATER) begin
        pos_d = pos_q + POS_SECOND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FIRST;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    q_item_o.ch_class  = CH_PLAIN;
    q_item_o.digit     = digit_of(char_code_i);
    q_item_o.pos       = pos_q;
    q_item_o.last      = last_char_i;
    q_item_o.is_quote  = (char_code_i == CHAR_QUOTE);
    q_item_o.char_code = char_code_i;
    if (char_code_i == CHAR_HASH) begin
      q_item_o.ch_class = CH_PFX_DEC;
    end else if (char_code_i == CHAR_DOLLAR) begin
      q_item_o.ch_class = CH_PFX_HEX;
    end else if (char_code_i == CHAR_PCT) begin
      q_item_o.ch_class = CH_PFX_BIN;
    end else if (char_code_i == CHAR_MINUS) begin
      q_item_o.ch_class = CH_MINUS;
    end
  end

endmodule

>>> hdl/fntp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fntp_queue: two-entry queue between front and back
// Register-based FIFO; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
module fntp_queue import fntp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tok_item_t push_item_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output tok_item_t head_o
);

  tok_item_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/fntp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fntp_back: token evaluation and result register
// Applies one character per cycle (a token end may wait) to the token state
// (radix, sign, saturating magnitude, literal detection); registers the result.
// ----------------------------------------------------------------------------
module fntp_back import fntp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RADIX_W-1:0] default_base_i,
  input  logic               q_valid_i,
  input  tok_item_t          q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [VALUE_W-1:0] number_value_o
);

  logic [RADIX_W-1:0] radix_q, radix_d, radix_eff;
  logic               sign_q, sign_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               seen_q, seen_d;
  logic               bad_q, bad_d;
  logic               lit_poss_q, lit_poss_d;
  logic [CHAR_W-1:0]  lit_byte_q, lit_byte_d;
  logic               out_valid_q;
  logic               ok_q, ok_d;
  logic [VALUE_W-1:0] value_q, value_d;

  logic               slot_free;
  logic               run_num;
  logic               take_minus;
  logic               digit_ok;
  logic               is_literal;
  logic [36:0]        mac;
  logic [VALUE_W-1:0] mag_low;

  // A character that closes a token needs the result register; others never wait.
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o   = q_valid_i && (!q_item_i.last || slot_free);

  assign mac = 37'(mag_q) * 37'(radix_eff) + 37'(q_item_i.digit);

  always_comb begin
    radix_d    = radix_q;
    sign_d     = sign_q;
    mag_d      = mag_q;
    seen_d     = seen_q;
    bad_d      = bad_q;
    lit_poss_d = lit_poss_q;
    lit_byte_d = lit_byte_q;
    radix_eff  = radix_q;
    run_num    = 1'b1;
    ok_d       = 1'b0;
    value_d    = '0;

    if (q_item_i.pos == POS_FIRST) begin
      lit_poss_d = q_item_i.is_quote;
      unique case (q_item_i.ch_class)
        CH_PFX_DEC: begin
          radix_d = RADIX_DEC;
          run_num = 1'b0;
        end
        CH_PFX_HEX: begin
          radix_d = RADIX_HEX;
          run_num = 1'b0;
        end
        CH_PFX_BIN: begin
          radix_d = RADIX_BIN;
          run_num = 1'b0;
        end
        default: begin
          radix_d   = default_base_i;
          radix_eff = default_base_i;
        end
      endcase
    end
    if (q_item_i.pos == POS_SECOND) begin
      lit_byte_d = q_item_i.char_code;
    end

    // A minus sign counts only right after the optional prefix.
    take_minus = (q_item_i.ch_class == CH_MINUS) && (q_item_i.pos <= POS_SECOND)
                 && !seen_q && !sign_q;
    digit_ok   = (radix_eff >= RADIX_MIN) && (radix_eff <= RADIX_MAX)
                 && (q_item_i.digit < radix_eff);

    if (run_num) begin
      if (take_minus) begin
        sign_d = 1'b1;
      end else if (!digit_ok) begin
        bad_d = 1'b1;
      end else begin
        seen_d = 1'b1;
        mag_d  = (mac > 37'(MAG_MAX)) ? MAG_MAX : mac[MAG_W-1:0];
      end
    end

    is_literal = q_item_i.last && (q_item_i.pos == POS_THIRD) && lit_poss_q
                 && q_item_i.is_quote;
    mag_low    = mag_d[VALUE_W-1:0];

    if (is_literal) begin
      ok_d    = 1'b1;
      value_d = VALUE_W'(lit_byte_q);
    end else if (!bad_d && seen_d) begin
      ok_d    = 1'b1;
      value_d = sign_d ? (VALUE_W'(0) - mag_low) : mag_low;
    end

    if (q_item_i.last) begin
      radix_d    = RESET_BASE;
      sign_d     = 1'b0;
      mag_d      = '0;
      seen_d     = 1'b0;
      bad_d      = 1'b0;
      lit_poss_d = 1'b0;
      lit_byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RESET_BASE;
      sign_q      <= 1'b0;
      mag_q       <= '0;
      seen_q      <= 1'b0;
      bad_q       <= 1'b0;
      lit_poss_q  <= 1'b0;
      lit_byte_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        radix_q    <= radix_d;
        sign_q     <= sign_d;
        mag_q      <= mag_d;
        seen_q     <= seen_d;
        bad_q      <= bad_d;
        lit_poss_q <= lit_poss_d;
        lit_byte_q <= lit_byte_d;
      end
      if (q_pop_o && q_item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.last) begin
      ok_q    <= ok_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign number_value_o = value_q;

endmodule

>>> hdl/forth_number_token_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forth_number_token_parser: streaming number token parser
// Converts a token of characters into a 24-bit number with radix prefix,
// minus sign, 31-bit magnitude saturation and quote-byte-quote literals.
// ----------------------------------------------------------------------------
//  Channel        Direction  Handshake                     Payload
//  character in   input      in_valid_i / in_ready_o       char_code_i, last_char_i
//  result out     output     out_valid_o / out_ready_i     ok_o, number_value_o
//  base register  input      default_base_we_i             default_base_i
//
//  One character is accepted per cycle while the queue has room. The last
//  character of a token is written into a queue entry, which the queue
//  presents at once; the back end applies one multiply-add by the radix
//  and registers the result when it takes that character from the queue.
//  Reset returns the default base to ten and clears any token in progress.
//  A stalled result holds the back end only at the next token end; the
//  queue then keeps that token end and takes one more character before
//  intake stalls.
// ----------------------------------------------------------------------------
module forth_number_token_parser import fntp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               default_base_we_i,
  input  logic [RADIX_W-1:0] default_base_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic               last_char_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [VALUE_W-1:0] number_value_o
);

  logic [RADIX_W-1:0] base_q;
  logic               q_push, q_ready, q_pop, q_valid;
  tok_item_t          push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RESET_BASE;
    end else if (default_base_we_i) begin
      base_q <= default_base_i;
    end
  end

  fntp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  fntp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  fntp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .default_base_i (base_q),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .number_value_o (number_value_o)
  );

  // A new result only follows a token end taken from the queue.
  a_result_from_token_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && head_item.last))
    else $error("result raised without a token end");

  // The back end never takes from an empty queue.
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A failed token always reports a zero value.
  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (number_value_o == '0))
    else $error("error result with nonzero value");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for forth_number_token_parser
// Sends number tokens one character request at a time, first from a short
// table of directed cases and then as random tokens under several default
// bases, and checks each result against the value typed in the table or
// an in-bench token predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import fntp_pkg::*;

  localparam int unsigned CHARS_PER_PHASE = 62;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned DIR_ROWS        = 25;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } number_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic               typed;
    logic               ok;
    logic [VALUE_W-1:0] value;
  } dir_row_t;

  // Expected results are typed in only on the closing character of a token.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, 24'h000000},
    '{8'h00,       1'b0, 1'b0, 1'b0, 24'h000000},
    '{CHAR_QUOTE,  1'b1, 1'b1, 1'b1, 24'h000000},
    '{CHAR_QUOTE,  1'b0, 1'b0, 1'b0, 24'h000000},
    '{8'hFF,       1'b0, 1'b0, 1'b0, 24'h000000},
    '{CHAR_QUOTE,  1'b1, 1'b1, 1'b1, 24'h0000FF},
    '{CHAR_MINUS,  1'b1, 1'b1, 1'b0, 24'h000000},
    '{CHAR_HASH,   1'b1, 1'b1, 1'b0, 24'h000000},
    '{CHAR_DOLLAR, 1'b0, 1'b0, 1'b0, 24'h000000},
    '{CHAR_MINUS,  1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b1, 1'b1, 1'b1, 24'hFFFFF1},
    '{CHAR_PCT,    1'b0, 1'b0, 1'b0, 24'h000000},
    '{"1",         1'b1, 1'b1, 1'b1, 24'h000001},
    '{"9",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{CHAR_MINUS,  1'b1, 1'b1, 1'b0, 24'h000000},
    '{8'h00,       1'b1, 1'b1, 1'b0, 24'h000000},
    '{CHAR_DOLLAR, 1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"F",         1'b0, 1'b0, 1'b0, 24'h000000},
    '{"f",         1'b1, 1'b1, 1'b1, 24'hFFFFFF}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               default_base_we_i;
  logic [RADIX_W-1:0] default_base_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CHAR_W-1:0]  char_code_i;
  logic               last_char_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               ok_o;
  logic [VALUE_W-1:0] number_value_o;

  // Directed expectation travelling with the current request.
  logic               row_typed;
  logic               row_ok;
  logic [VALUE_W-1:0] row_value;

  // Predictor state.
  logic [RADIX_W-1:0] base_reg = RESET_BASE;
  logic [POS_W-1:0]   tok_pos = POS_FIRST;
  logic [CHAR_W-1:0]  quoted_byte = '0;
  logic               quote_open = 1'b0;
  logic [RADIX_W-1:0] tok_radix = RESET_BASE;
  logic               tok_neg = 1'b0;
  logic [MAG_W-1:0]   tok_mag = '0;
  logic               tok_has_digit = 1'b0;
  logic               tok_bad = 1'b0;

  number_result_t     pending_results[$];
  logic [CHAR_W-1:0]  token_chars[$];
  int unsigned        fail_count = 0;
  int unsigned        idle_cycles = 0;
  logic               steady_in = 1'b0;

  forth_number_token_parser uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .default_base_we_i(default_base_we_i),
    .default_base_i   (default_base_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .last_char_i      (last_char_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ok_o             (ok_o),
    .number_value_o   (number_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [RADIX_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return RADIX_W'(c - "0");
    if (c >= "a" && c <= "z") return RADIX_W'(c - "a" + 8'd10);
    if (c >= "A" && c <= "Z") return RADIX_W'(c - "A" + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    if (d < 10) return "0" + CHAR_W'(d);
    if ($urandom_range(0, 1) == 0) return "a" + CHAR_W'(d - 10);
    return "A" + CHAR_W'(d - 10);
  endfunction

  task automatic clear_token();
    tok_pos = POS_FIRST;
    quoted_byte = '0;
    quote_open = 1'b0;
    tok_radix = RESET_BASE;
    tok_neg = 1'b0;
    tok_mag = '0;
    tok_has_digit = 1'b0;
    tok_bad = 1'b0;
  endtask

  task automatic take_char(input logic [CHAR_W-1:0] c);
    logic [RADIX_W-1:0] d;
    logic [63:0]        next_mag;
    if (c == CHAR_MINUS && tok_pos <= POS_SECOND && !tok_has_digit && !tok_neg) begin
      tok_neg = 1'b1;
    end else begin
      d = char_digit(c);
      if (tok_radix < RADIX_MIN || tok_radix > RADIX_MAX || d >= tok_radix) begin
        tok_bad = 1'b1;
      end else begin
        tok_has_digit = 1'b1;
        next_mag = 64'(tok_mag) * 64'(tok_radix) + 64'(d);
        tok_mag = (next_mag > 64'(MAG_MAX)) ? MAG_MAX : next_mag[MAG_W-1:0];
      end
    end
  endtask

  task automatic predict_char(input logic [CHAR_W-1:0] c, input logic last,
                              output logic has_res, output number_result_t res);
    logic        literal_hit;
    logic [31:0] signed_val;
    literal_hit = last && tok_pos == POS_THIRD && quote_open && c == CHAR_QUOTE;
    if (tok_pos == POS_FIRST) begin
      quote_open = (c == CHAR_QUOTE);
      case (c)
        CHAR_HASH:   tok_radix = RADIX_DEC;
        CHAR_DOLLAR: tok_radix = RADIX_HEX;
        CHAR_PCT:    tok_radix = RADIX_BIN;
        default: begin
          tok_radix = base_reg;
          take_char(c);
        end
      endcase
    end else begin
      if (tok_pos == POS_SECOND) quoted_byte = c;
      take_char(c);
    end
    if (tok_pos != POS_LATER) tok_pos = tok_pos + 1'b1;
    has_res = last;
    res = '0;
    if (last) begin
      if (literal_hit) begin
        res.ok = 1'b1;
        res.value = VALUE_W'(quoted_byte);
      end else if (!tok_bad && tok_has_digit) begin
        signed_val = tok_neg ? -{1'b0, tok_mag} : {1'b0, tok_mag};
        res.ok = 1'b1;
        res.value = signed_val[VALUE_W-1:0];
      end
      clear_token();
    end
  endtask

  always @(posedge clk_i) begin : monitor
    logic           has_res;
    logic           fired;
    number_result_t res;
    number_result_t want;
    if (rst_ni) begin
      fired = 1'b0;
      if (default_base_we_i) base_reg = default_base_i;
      if (in_valid_i && in_ready_o) begin
        fired = 1'b1;
        predict_char(char_code_i, last_char_i, has_res, res);
        if (has_res) begin
          pending_results.push_back(row_typed ? number_result_t'({row_ok, row_value}) : res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        fired = 1'b1;
        if (pending_results.size() == 0) begin
          $error("unexpected result: ok %0b, number_value %h", ok_o, number_value_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (ok_o !== want.ok) begin
            $error("ok mismatch: expected %0b, actual %0b", want.ok, ok_o);
            fail_count++;
          end
          if (number_value_o !== want.value) begin
            $error("number_value mismatch: expected %h, actual %h", want.value,
                   number_value_o);
            fail_count++;
          end
        end
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: stretches of steady readiness mixed with short and long stalls.
  initial begin : result_sink
    int unsigned hold;
    int unsigned pick;
    out_ready_i = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_ready_i = 1'b1;
          hold = $urandom_range(4, 40);
        end else if (pick < 88) begin
          out_ready_i = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ready_i = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (steady_in) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drive_char(input logic [CHAR_W-1:0] ch, input logic last,
                            input logic typed, input logic ok,
                            input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    char_code_i = ch;
    last_char_i = last;
    row_typed = typed;
    row_ok = ok;
    row_value = value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_base(input logic [RADIX_W-1:0] b);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    default_base_we_i = 1'b1;
    default_base_i = b;
    @(negedge clk_i);
    default_base_we_i = 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] odd_char();
    case ($urandom_range(0, 7))
      0: return CHAR_HASH;
      1: return CHAR_DOLLAR;
      2: return CHAR_PCT;
      3: return CHAR_MINUS;
      4: return CHAR_QUOTE;
      5: return 8'h00;
      6: return "z";
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Optional prefix, optional sign, then digits for the radix, base 36 if invalid.
  task automatic push_number();
    logic [RADIX_W-1:0] radix;
    int unsigned        len;
    int unsigned        pick;
    case ($urandom_range(0, 3))
      0: begin
        radix = base_reg;
      end
      1: begin
        radix = RADIX_DEC;
        token_chars.push_back(CHAR_HASH);
      end
      2: begin
        radix = RADIX_HEX;
        token_chars.push_back(CHAR_DOLLAR);
      end
      default: begin
        radix = RADIX_BIN;
        token_chars.push_back(CHAR_PCT);
      end
    endcase
    // An out-of-range base has no digits; any alphanumeric then makes an error.
    if (radix < RADIX_MIN || radix > RADIX_MAX) radix = RADIX_MAX;
    if ($urandom_range(0, 2) == 0) token_chars.push_back(CHAR_MINUS);
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(1, 4);
    else if (pick < 90) len = $urandom_range(5, 10);
    else len = $urandom_range(11, (radix <= 4) ? 34 : 14);
    repeat (len) token_chars.push_back(digit_char(RADIX_W'($urandom_range(0, radix - 1))));
  endtask

  task automatic make_token();
    int unsigned kind;
    int unsigned spot;
    token_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      push_number();
    end else if (kind < 60) begin
      token_chars.push_back(CHAR_QUOTE);
      token_chars.push_back(CHAR_W'($urandom_range(0, 255)));
      token_chars.push_back(CHAR_QUOTE);
    end else if (kind < 68) begin
      token_chars.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 3)) token_chars.push_back(odd_char());
      if ($urandom_range(0, 1) == 0) token_chars.push_back(CHAR_QUOTE);
    end else if (kind < 85) begin
      push_number();
      spot = $urandom_range(0, token_chars.size() - 1);
      token_chars[spot] = odd_char();
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 0) token_chars.push_back(odd_char());
        else token_chars.push_back(digit_char(RADIX_W'($urandom_range(0, 35))));
      end
    end
  endtask

  task automatic run_random_phase();
    int unsigned sent;
    int unsigned i;
    sent = 0;
    while (sent < CHARS_PER_PHASE) begin
      make_token();
      if ($urandom_range(0, 7) == 0) steady_in = ~steady_in;
      for (i = 0; i < token_chars.size(); i++) begin
        drive_char(token_chars[i], i == token_chars.size() - 1, 1'b0, 1'b0, '0);
      end
      sent += token_chars.size();
    end
  endtask

  initial begin : stimulus
    logic [RADIX_W-1:0] base_plan [10];
    int unsigned        i;
    rst_ni = 1'b0;
    default_base_we_i = 1'b0;
    default_base_i = '0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    row_typed = 1'b0;
    row_ok = 1'b0;
    row_value = '0;
    base_plan = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd63, 6'd1, 6'd37,
                  RADIX_W'($urandom_range(2, 36)), RADIX_W'($urandom_range(0, 63)), 6'd10};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases run at the reset base.
    for (i = 0; i < DIR_ROWS; i++) begin
      drive_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed,
                 DIRECTED[i].ok, DIRECTED[i].value);
    end
    run_random_phase();
    for (i = 0; i < 10; i++) begin
      write_base(base_plan[i]);
      run_random_phase();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
